[hw/rtl/pwlte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlte_pkg: shared types and constants of the piecewise linear table evaluator
// Payload structs, operation and status codes, sequencer state encodings.
// ----------------------------------------------------------------------------
package pwlte_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_VALUE  = 2'd1,
        OP_INTEG  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_INVALID = 2'd2,
        ST_SAT     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         entry_index;
        logic signed [31:0] entry_x;
        logic signed [31:0] entry_y;
        logic signed [31:0] query_x;
        logic signed [31:0] query_x_end;
    } req_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic signed [63:0] integral_out;
        logic [1:0]         status;
    } rsp_t;

    typedef logic [6:0] cfg_t;

    // Interpolation subroutine return points
    typedef enum logic [2:0] {
        RET_VAL,
        RET_SA,
        RET_SB,
        RET_PA,
        RET_PB
    } ret_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_OUT,
        S_RET,
        I_RA,
        I_RB,
        I_RC,
        I_SCAN,
        I_SCANW,
        I_MW,
        I_DINIT,
        I_DIV,
        I_FIN,
        G_RA,
        G_RB,
        G_RC,
        G_ID1,
        G_ID1W,
        G_ID2,
        G_ID2W,
        G_SEG,
        G_SEGA,
        G_SEGB,
        G_PA,
        G_PAR,
        G_PARW,
        G_PB,
        G_PBR,
        G_PBRW,
        G_MW,
        G_ACC,
        G_NEG,
        G_FIN
    } state_t;

    // Magnitude of a 33 bit signed difference
    function automatic logic signed [33:0] mag34(input logic signed [32:0] v);
        logic signed [33:0] e;
        e = 34'(v);
        return v[32] ? -e : e;
    endfunction

endpackage

[hw/rtl/pwlte_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlte_stream_if: valid/ready channel
// Carries one payload per transfer; payload type set per instance.
// ----------------------------------------------------------------------------
interface pwlte_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/piecewise_linear_table_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_eval: breakpoint table with interpolate and integrate
// Sequencer around one table RAM, one 34x34 multiplier and a radix-2 divider.
// ----------------------------------------------------------------------------
// Usage:
//   req : items of pwlte_pkg::req_t. Write stores one breakpoint, value
//         interpolates at query_x, integrate sums area from query_x to
//         query_x_end.
//   rsp : one pwlte_pkg::rsp_t per request, held until transferred.
//   cfg : entry_count, to be written only while the block is idle; the
//         block itself does not enforce this. cfg is always ready.
// Operation steps:
//   write or empty table: response set up straight from idle.
//   value: table scan, one multiply, 64-step divide.
//   integrate: one multiply per whole segment plus up to two interpolations.
//   The 64-step divide and the single table read port set the run time.
// One request at a time: req.ready is low from the accepted transfer until
// the response has been taken. A stalled rsp holds its payload and keeps the
// block busy. Reset returns to idle with entry_count 0; the table contents
// are not cleared and must be written before use.
// ----------------------------------------------------------------------------
module piecewise_linear_table_eval #(
    parameter int MAX_ENTRIES = pwlte_pkg::MAX_ENTRIES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    pwlte_stream_if.sink    req,
    pwlte_stream_if.source  rsp,
    pwlte_stream_if.sink    cfg
);
    import pwlte_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // table RAM: {x, y} per entry, registered read
    logic [63:0]    mem [MAX_ENTRIES];
    logic [AW-1:0]  mem_raddr;
    logic [63:0]    rd_q;
    logic           mem_we;
    logic signed [31:0] rd_x, rd_y;

    state_t state_reg, state_next;
    state_t post_reg, post_next;
    ret_t   ret_reg, ret_next;
    cfg_t   count_reg;
    logic [CW-1:0] n_w;

    logic signed [31:0] ga_reg, ga_next, gb_reg, gb_next;
    logic swap_reg, swap_next, sat_reg, sat_next;
    logic signed [31:0] ix_reg, ix_next, ax_reg, ax_next, ay_reg, ay_next;
    logic signed [31:0] xf_reg, xf_next;
    logic [CW-1:0] i_reg, i_next, id1_reg, id1_next, id2_reg, id2_next;
    logic signed [31:0] iv_reg, iv_next, va_reg, va_next;
    logic [1:0] ist_reg, ist_next;
    logic [32:0] ud_reg, ud_next;
    logic neg_reg, neg_next;
    logic signed [33:0] mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic signed [67:0] prod_reg;
    logic signed [79:0] acc_reg, acc_next;
    logic [63:0] quo_reg, quo_next;
    logic [33:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic signed [31:0] value_reg, value_next;
    logic signed [63:0] integral_reg, integral_next;
    logic [1:0] status_reg, status_next;

    // datapath helpers
    logic signed [32:0] dx_w, dy_w, d_w;
    logic [33:0]        rem_sh;
    logic [33:0]        qc_w;
    logic signed [35:0] qs_w, r_w;
    logic signed [79:0] t_w, h_w;
    logic               fits_w;

    assign rd_x = $signed(rd_q[63:32]);
    assign rd_y = $signed(rd_q[31:0]);

    // entry counts above the table depth act as the full table
    assign n_w = (32'(count_reg) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(count_reg);

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.data.value_out    = value_reg;
    assign rsp.data.integral_out = integral_reg;
    assign rsp.data.status       = status_reg;

    assign mem_we = req.valid && req.ready && (req.data.operation == OP_WRITE)
                    && (32'(req.data.entry_index) < 32'(MAX_ENTRIES));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(req.data.entry_index)] <= {req.data.entry_x, req.data.entry_y};
        end
        rd_q <= mem[mem_raddr];
    end

    // shared multiplier, operands loaded one state ahead
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a_reg * mul_b_reg;
    end

    assign dx_w = 33'(ix_reg) - 33'(ax_reg);
    assign dy_w = 33'(rd_y) - 33'(ay_reg);
    assign d_w  = 33'(rd_x) - 33'(ax_reg);
    assign rem_sh = {rem_reg[32:0], quo_reg[63]};

    // quotient clamp and rounding result of the interpolation
    assign qc_w = (quo_reg > 64'h2_0000_0000) ? 34'h2_0000_0000 : quo_reg[33:0];
    assign qs_w = $signed({2'b00, qc_w});
    assign r_w  = 36'(ay_reg) + (neg_reg ? -qs_w : qs_w);

    // halve the doubled area, ties toward plus infinity
    assign t_w    = acc_reg + 80'sd1;
    assign h_w    = t_w >>> 1;
    assign fits_w = (h_w[79:63] == '0) || (h_w[79:63] == '1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                count_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        post_reg     <= post_next;
        ret_reg      <= ret_next;
        ga_reg       <= ga_next;
        gb_reg       <= gb_next;
        swap_reg     <= swap_next;
        sat_reg      <= sat_next;
        ix_reg       <= ix_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        xf_reg       <= xf_next;
        i_reg        <= i_next;
        id1_reg      <= id1_next;
        id2_reg      <= id2_next;
        iv_reg       <= iv_next;
        va_reg       <= va_next;
        ist_reg      <= ist_next;
        ud_reg       <= ud_next;
        neg_reg      <= neg_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        acc_reg      <= acc_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        value_reg    <= value_next;
        integral_reg <= integral_next;
        status_reg   <= status_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        post_next     = post_reg;
        ret_next      = ret_reg;
        ga_next       = ga_reg;
        gb_next       = gb_reg;
        swap_next     = swap_reg;
        sat_next      = sat_reg;
        ix_next       = ix_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        xf_next       = xf_reg;
        i_next        = i_reg;
        id1_next      = id1_reg;
        id2_next      = id2_reg;
        iv_next       = iv_reg;
        va_next       = va_reg;
        ist_next      = ist_reg;
        ud_next       = ud_reg;
        neg_next      = neg_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        acc_next      = acc_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        value_next    = value_reg;
        integral_next = integral_reg;
        status_next   = status_reg;
        mem_raddr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    value_next    = '0;
                    integral_next = '0;
                    status_next   = ST_OK;
                    state_next    = S_OUT;
                    case (req.data.operation)
                        OP_VALUE:
                        begin
                            if (n_w == '0)
                            begin
                                status_next = ST_INVALID;
                            end
                            else
                            begin
                                ix_next    = req.data.query_x;
                                ret_next   = RET_VAL;
                                state_next = I_RA;
                            end
                        end
                        OP_INTEG:
                        begin
                            if (n_w == '0)
                            begin
                                status_next = ST_INVALID;
                            end
                            else
                            begin
                                swap_next = req.data.query_x > req.data.query_x_end;
                                if (req.data.query_x > req.data.query_x_end)
                                begin
                                    ga_next = req.data.query_x_end;
                                    gb_next = req.data.query_x;
                                end
                                else
                                begin
                                    ga_next = req.data.query_x;
                                    gb_next = req.data.query_x_end;
                                end
                                acc_next   = '0;
                                sat_next   = 1'b0;
                                state_next = G_RA;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            // ---- interpolation subroutine ----
            I_RA:
            begin
                mem_raddr  = '0;
                state_next = I_RB;
            end

            I_RB:
            begin
                ax_next    = rd_x;
                ay_next    = rd_y;
                mem_raddr  = AW'(n_w - CW'(1));
                state_next = I_RC;
            end

            I_RC:
            begin
                if (ix_reg < ax_reg || ix_reg > rd_x)
                begin
                    iv_next    = '0;
                    ist_next   = ST_RANGE;
                    state_next = S_RET;
                end
                else if (n_w == CW'(1))
                begin
                    iv_next    = ay_reg;
                    ist_next   = ST_OK;
                    state_next = S_RET;
                end
                else
                begin
                    i_next     = '0;
                    state_next = I_SCAN;
                end
            end

            I_SCAN:
            begin
                mem_raddr  = AW'(i_reg + CW'(1));
                state_next = I_SCANW;
            end

            I_SCANW:
            begin
                if (int'(i_reg) < int'(n_w) - 2 && rd_x < ix_reg)
                begin
                    ax_next    = rd_x;
                    ay_next    = rd_y;
                    i_next     = i_reg + CW'(1);
                    state_next = I_SCAN;
                end
                else if (d_w == '0)
                begin
                    iv_next    = '0;
                    ist_next   = ST_INVALID;
                    state_next = S_RET;
                end
                else
                begin
                    mul_a_next = mag34(dx_w);
                    mul_b_next = mag34(dy_w);
                    ud_next    = 33'(mag34(d_w));
                    neg_next   = (dx_w[32] ^ dy_w[32]) ^ d_w[32];
                    state_next = I_MW;
                end
            end

            I_MW:
            begin
                state_next = I_DINIT;
            end

            I_DINIT:
            begin
                // rounding bias added in 64 bits, wrapping
                quo_next   = prod_reg[63:0] + 64'(ud_reg >> 1);
                rem_next   = '0;
                cnt_next   = 7'd64;
                state_next = I_DIV;
            end

            I_DIV:
            begin
                if (rem_sh >= {1'b0, ud_reg})
                begin
                    rem_next = rem_sh - {1'b0, ud_reg};
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    state_next = I_FIN;
                end
            end

            I_FIN:
            begin
                if (r_w > 36'sd2147483647)
                begin
                    iv_next  = 32'sh7FFFFFFF;
                    ist_next = ST_SAT;
                end
                else if (r_w < -36'sd2147483648)
                begin
                    iv_next  = 32'sh80000000;
                    ist_next = ST_SAT;
                end
                else
                begin
                    iv_next  = r_w[31:0];
                    ist_next = ST_OK;
                end
                state_next = S_RET;
            end

            S_RET:
            begin
                if (ret_reg != RET_VAL && ist_reg == ST_INVALID)
                begin
                    value_next    = '0;
                    integral_next = '0;
                    status_next   = ST_INVALID;
                    state_next    = S_OUT;
                end
                else
                begin
                    sat_next = sat_reg || (ist_reg == ST_SAT);
                    va_next  = iv_reg;
                    unique case (ret_reg)
                        RET_VAL:
                        begin
                            value_next    = (ist_reg == ST_OK || ist_reg == ST_SAT) ? iv_reg : '0;
                            integral_next = '0;
                            status_next   = ist_reg;
                            state_next    = S_OUT;
                        end
                        RET_SA:
                        begin
                            ix_next    = gb_reg;
                            ret_next   = RET_SB;
                            state_next = I_RA;
                        end
                        RET_SB:
                        begin
                            mul_a_next = 34'(va_reg) + 34'(iv_reg);
                            mul_b_next = 34'(gb_reg) - 34'(ga_reg);
                            post_next  = G_NEG;
                            state_next = G_MW;
                        end
                        RET_PA:
                        begin
                            state_next = G_PAR;
                        end
                        RET_PB:
                        begin
                            state_next = G_PBR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // ---- integration ----
            G_RA:
            begin
                mem_raddr  = '0;
                state_next = G_RB;
            end

            G_RB:
            begin
                xf_next    = rd_x;
                mem_raddr  = AW'(n_w - CW'(1));
                state_next = G_RC;
            end

            G_RC:
            begin
                if (ga_reg > rd_x || gb_reg < xf_reg)
                begin
                    value_next    = '0;
                    integral_next = '0;
                    status_next   = ST_RANGE;
                    state_next    = S_OUT;
                end
                else
                begin
                    id1_next   = '0;
                    state_next = G_ID1;
                end
            end

            G_ID1:
            begin
                mem_raddr  = AW'(id1_reg);
                state_next = G_ID1W;
            end

            G_ID1W:
            begin
                if (int'(id1_reg) < int'(n_w) - 1 && rd_x < ga_reg)
                begin
                    id1_next   = id1_reg + CW'(1);
                    state_next = G_ID1;
                end
                else
                begin
                    id2_next   = n_w - CW'(1);
                    state_next = G_ID2;
                end
            end

            G_ID2:
            begin
                mem_raddr  = AW'(id2_reg);
                state_next = G_ID2W;
            end

            G_ID2W:
            begin
                if (id2_reg != '0 && rd_x > gb_reg)
                begin
                    id2_next   = id2_reg - CW'(1);
                    state_next = G_ID2;
                end
                else if (int'(id1_reg) == int'(id2_reg) + 1)
                begin
                    // both bounds inside one segment: single trapezoid
                    ix_next    = ga_reg;
                    ret_next   = RET_SA;
                    state_next = I_RA;
                end
                else
                begin
                    i_next     = id1_reg;
                    state_next = G_SEG;
                end
            end

            G_SEG:
            begin
                mem_raddr = AW'(i_reg);
                if (i_reg < id2_reg)
                begin
                    state_next = G_SEGA;
                end
                else
                begin
                    state_next = G_PA;
                end
            end

            G_SEGA:
            begin
                ax_next    = rd_x;
                ay_next    = rd_y;
                mem_raddr  = AW'(i_reg + CW'(1));
                state_next = G_SEGB;
            end

            G_SEGB:
            begin
                mul_a_next = 34'(ay_reg) + 34'(rd_y);
                mul_b_next = 34'(rd_x) - 34'(ax_reg);
                i_next     = i_reg + CW'(1);
                post_next  = G_SEG;
                state_next = G_MW;
            end

            G_PA:
            begin
                if (id1_reg != '0)
                begin
                    ix_next    = ga_reg;
                    ret_next   = RET_PA;
                    state_next = I_RA;
                end
                else
                begin
                    state_next = G_PB;
                end
            end

            G_PAR:
            begin
                mem_raddr  = AW'(id1_reg);
                state_next = G_PARW;
            end

            G_PARW:
            begin
                mul_a_next = 34'(va_reg) + 34'(rd_y);
                mul_b_next = 34'(rd_x) - 34'(ga_reg);
                post_next  = G_PB;
                state_next = G_MW;
            end

            G_PB:
            begin
                if (int'(id2_reg) < int'(n_w) - 1)
                begin
                    ix_next    = gb_reg;
                    ret_next   = RET_PB;
                    state_next = I_RA;
                end
                else
                begin
                    state_next = G_NEG;
                end
            end

            G_PBR:
            begin
                mem_raddr  = AW'(id2_reg);
                state_next = G_PBRW;
            end

            G_PBRW:
            begin
                mul_a_next = 34'(rd_y) + 34'(va_reg);
                mul_b_next = 34'(gb_reg) - 34'(rd_x);
                post_next  = G_NEG;
                state_next = G_MW;
            end

            G_MW:
            begin
                state_next = G_ACC;
            end

            G_ACC:
            begin
                acc_next   = acc_reg + 80'(prod_reg);
                state_next = post_reg;
            end

            G_NEG:
            begin
                if (swap_reg)
                begin
                    acc_next = -acc_reg;
                end
                state_next = G_FIN;
            end

            G_FIN:
            begin
                value_next = '0;
                if (fits_w)
                begin
                    integral_next = h_w[63:0];
                    status_next   = sat_reg ? ST_SAT : ST_OK;
                end
                else
                begin
                    integral_next = h_w[79] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
                    status_next   = ST_SAT;
                end
                state_next = S_OUT;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/pwlte_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlte_checker: port-level checks of the table evaluator
// One request in flight, held responses, ready after transfer, zeroed payload on error, one result kind.
// ----------------------------------------------------------------------------
module pwlte_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input pwlte_pkg::rsp_t rsp_data
);
    import pwlte_pkg::*;

    // a pending response blocks new requests
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request accepted while a response is pending");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled response changed");

    a_free_after_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |=> req_ready)
        else $error("not ready after response transfer");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == ST_RANGE || rsp_data.status == ST_INVALID)
        |-> rsp_data.value_out == '0 && rsp_data.integral_out == '0)
        else $error("nonzero payload with error status");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.value_out == '0 || rsp_data.integral_out == '0)
        else $error("value and integral both nonzero");

endmodule

bind piecewise_linear_table_eval pwlte_checker u_pwlte_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
